// ----- hdl/lru_recency_tracker_macros.svh -----
// Assertion helpers
`ifndef LRU_RECENCY_TRACKER_MACROS_SVH
`define LRU_RECENCY_TRACKER_MACROS_SVH
`define LRT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define LRT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`endif

// ----- hdl/lrt_pkg.sv -----
package lrt_pkg;
  localparam int REQ_BITS = 1;
  localparam int STATUS_BITS = 3;
  localparam int OCC_BITS = 5;
  localparam int KEY_PORT_BITS = 32;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_TOUCH = 1'b0,
    REQ_EVICT = 1'b1
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED = 3'd0,
    ST_HIT      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;
endpackage

// ----- hdl/lrt_front.sv -----
module lrt_front
  import lrt_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_BITS-1:0]      req_type,
  input  logic [KEY_PORT_BITS-1:0] key,
  output logic                     q_valid,
  input  logic                     q_take,
  output req_t                     q_req,
  output logic [KEY_BITS-1:0]      q_key
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  req_t                fifo_req [DEPTH];
  logic [KEY_BITS-1:0] fifo_key [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;
  logic                push;
  logic                pop;
  logic [KEY_BITS-1:0] key_tag;

  always_comb begin
    key_tag = KEY_BITS'(key);
  end

  assign in_stall = (count == (PW+1)'(DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_take;
  assign q_req = fifo_req[rd_ptr];
  assign q_key = fifo_key[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_req[wr_ptr] <= req_t'(req_type);
      fifo_key[wr_ptr] <= key_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// ----- hdl/lrt_back.sv -----
`include "lru_recency_tracker_macros.svh"
module lrt_back
  import lrt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_take,
  input  req_t                     q_req,
  input  logic [KEY_BITS-1:0]      q_key,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_BITS-1:0]   status,
  output logic [KEY_PORT_BITS-1:0] evicted_key,
  output logic [OCC_BITS-1:0]      occupancy
);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] slots [ENTRIES];
  logic [CW-1:0]       slot_count;
  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  keep;
  logic                found;
  logic                full;
  logic                empty;
  logic                fire;
  status_t             st_next;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CW'(i) < slot_count) && (slots[i] == q_key);
    end
  end

  // keep[i]: slot i lies before the removed slot
  always_comb begin
    keep[0] = !match[0];
    for (int i = 1; i < ENTRIES; i++) begin
      keep[i] = keep[i-1] && !match[i];
    end
  end

  assign found = |match;
  assign full  = (slot_count == CW'(ENTRIES));
  assign empty = (slot_count == '0);
  assign q_take = !out_valid || !out_stall;
  assign fire = q_valid && q_take;

  always_comb begin
    priority if (q_req == REQ_EVICT) begin
      st_next = empty ? ST_EMPTY : ST_EVICTED;
    end else if (found) begin
      st_next = ST_HIT;
    end else if (!full) begin
      st_next = ST_INSERTED;
    end else begin
      st_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (st_next)
        ST_EVICTED: begin
          for (int i = 0; i + 1 < ENTRIES; i++) slots[i] <= slots[i+1];
        end
        ST_HIT: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!keep[i]) begin
              if (CW'(i) + 1'b1 == slot_count) slots[i] <= q_key;
              else if (i + 1 < ENTRIES) slots[i] <= slots[(i + 1) % ENTRIES];
            end
          end
        end
        ST_INSERTED: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (CW'(i) == slot_count) slots[i] <= q_key;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (st_next == ST_EVICTED) slot_count <= slot_count - 1'b1;
        else if (st_next == ST_INSERTED) slot_count <= slot_count + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= st_next;
      evicted_key <= (st_next == ST_EVICTED) ? KEY_PORT_BITS'(slots[0]) : '0;
      unique case (st_next)
        ST_EVICTED:  occupancy <= OCC_BITS'(slot_count - 1'b1);
        ST_INSERTED: occupancy <= OCC_BITS'(slot_count + 1'b1);
        default:     occupancy <= OCC_BITS'(slot_count);
      endcase
    end
  end

  `LRT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, slot_count <= CW'(ENTRIES))
  `LRT_ASSERT_IMP(a_one_match, clk, rst, q_valid, $onehot0(match))
  `LRT_ASSERT_NEXT(a_insert_grows, clk, rst, fire && st_next == ST_INSERTED, slot_count == $past(slot_count) + 1'b1)
endmodule

// ----- hdl/lru_recency_tracker.sv -----
// LRU replacement list holding up to ENTRIES key tags. Touch inserts a new key as most
// recent or moves a stored key there; evict returns the least recent key. A request enters
// a two-deep queue and a back end with one comparator per slot serves one request per
// cycle while out_stall is low; results are registered. A touch on a full list with a new
// key is dropped with a full status, an evict on an empty list reports empty.
module lru_recency_tracker
  import lrt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_BITS-1:0]      req_type,
  input  logic [KEY_PORT_BITS-1:0] key,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_BITS-1:0]   status,
  output logic [KEY_PORT_BITS-1:0] evicted_key,
  output logic [OCC_BITS-1:0]      occupancy
);
  logic                q_valid;
  logic                q_take;
  req_t                q_req;
  logic [KEY_BITS-1:0] q_key;

  lrt_front #(.KEY_BITS(KEY_BITS), .DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .key,
    .q_valid, .q_take, .q_req, .q_key
  );

  lrt_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_req, .q_key,
    .out_valid, .out_stall, .status, .evicted_key, .occupancy
  );
endmodule
